// ===== rtl/core/swt_pkg.sv =====
// Shared types and constants for the shell word tokenizer.
`default_nettype none
package swt_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Max results one input byte can cause, and queue depth in bundles.
  localparam int MAX_RES = 4;
  localparam int QDEPTH  = 2;
  localparam int RIDX_W  = $clog2(MAX_RES);
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_WORD = 2'd1,
    KIND_LINE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    ESC_NONE   = 2'd0,
    ESC_PLAIN  = 2'd1,
    ESC_DOUBLE = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic       last_in_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
  } res_t;

  // All results of one input byte; last_idx is the index of the final one.
  typedef struct packed {
    logic [RIDX_W-1:0]  last_idx;
    res_t [MAX_RES-1:0] res;
  } bundle_t;

endpackage
`default_nettype wire

// ===== rtl/core/swt_front.sv =====
// Front end: accepts bytes, tracks quote/escape state, builds result bundles.
`default_nettype none
module swt_front
  import swt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          q_push,
  output bundle_t       q_data
);

  quote_t quote_mode, quote_mode_next;
  esc_t   escape_pending, escape_pending_next;
  logic   word_open, word_open_next;

  logic [2:0] n;
  logic [2:0] n_m1;
  logic       do_plain;
  logic [7:0] c;
  logic       take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign c        = in_item.in_byte;

  always_comb begin
    quote_mode_next     = quote_mode;
    escape_pending_next = escape_pending;
    word_open_next      = word_open;
    n                   = 3'd0;
    do_plain            = 1'b0;
    q_data              = '0;

    if (escape_pending == ESC_PLAIN) begin
      escape_pending_next = ESC_NONE;
      q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
      n = n + 3'd1;
      word_open_next = 1'b1;
    end else if (escape_pending == ESC_DOUBLE) begin
      escape_pending_next = ESC_NONE;
      if (c == CH_DQUOTE || c == CH_BSLASH) begin
        q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
        n = n + 3'd1;
        word_open_next = 1'b1;
      end else begin
        // backslash not escaping anything inside double quotes is kept
        q_data.res[n[RIDX_W-1:0]] = '{out_byte: CH_BSLASH, kind: KIND_BYTE};
        n = n + 3'd1;
        word_open_next = 1'b1;
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (c == CH_BSLASH) begin
        if (quote_mode == Q_SINGLE) begin
          q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
          n = n + 3'd1;
          word_open_next = 1'b1;
        end else if (quote_mode == Q_DOUBLE) begin
          escape_pending_next = ESC_DOUBLE;
        end else begin
          escape_pending_next = ESC_PLAIN;
        end
      end else if (c == CH_SQUOTE) begin
        if (quote_mode == Q_DOUBLE) begin
          q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
          n = n + 3'd1;
          word_open_next = 1'b1;
        end else if (quote_mode == Q_SINGLE) begin
          quote_mode_next = Q_NONE;
        end else begin
          quote_mode_next = Q_SINGLE;
        end
      end else if (c == CH_DQUOTE) begin
        if (quote_mode == Q_SINGLE) begin
          q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
          n = n + 3'd1;
          word_open_next = 1'b1;
        end else if (quote_mode == Q_DOUBLE) begin
          quote_mode_next = Q_NONE;
        end else begin
          quote_mode_next = Q_DOUBLE;
        end
      end else if (c == CH_SPACE || c == CH_TAB) begin
        if (quote_mode == Q_SINGLE || quote_mode == Q_DOUBLE) begin
          q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
          n = n + 3'd1;
          word_open_next = 1'b1;
        end else if (word_open_next) begin
          q_data.res[n[RIDX_W-1:0]] = '{out_byte: 8'd0, kind: KIND_WORD};
          n = n + 3'd1;
          word_open_next = 1'b0;
        end
      end else begin
        q_data.res[n[RIDX_W-1:0]] = '{out_byte: c, kind: KIND_BYTE};
        n = n + 3'd1;
        word_open_next = 1'b1;
      end
    end

    if (in_item.line_last) begin
      if (escape_pending_next == ESC_DOUBLE) begin
        q_data.res[n[RIDX_W-1:0]] = '{out_byte: CH_BSLASH, kind: KIND_BYTE};
        n = n + 3'd1;
        word_open_next = 1'b1;
      end
      escape_pending_next = ESC_NONE;
      if (word_open_next) begin
        q_data.res[n[RIDX_W-1:0]] = '{out_byte: 8'd0, kind: KIND_WORD};
        n = n + 3'd1;
      end
      q_data.res[n[RIDX_W-1:0]] = '{out_byte: 8'd0, kind: KIND_LINE};
      n = n + 3'd1;
      quote_mode_next = Q_NONE;
      word_open_next  = 1'b0;
    end

    n_m1 = n - 3'd1;
    q_data.last_idx = n_m1[RIDX_W-1:0];
  end

  assign q_push = take && (n != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode     <= Q_NONE;
      escape_pending <= ESC_NONE;
      word_open      <= 1'b0;
    end else if (take) begin
      quote_mode     <= quote_mode_next;
      escape_pending <= escape_pending_next;
      word_open      <= word_open_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/swt_queue.sv =====
// Short bundle queue between front end and back end.
`default_nettype none
module swt_queue
  import swt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  input  wire logic    pop,
  output logic         full,
  output logic         empty,
  output bundle_t      head
);

  bundle_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/swt_back.sv =====
// Back end: walks the head bundle and presents one result per transfer.
`default_nettype none
module swt_back
  import swt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_empty,
  input  wire bundle_t q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_item
);

  logic [RIDX_W-1:0] idx;
  logic              at_last;
  logic              xfer;

  assign out_valid = !q_empty;
  assign at_last   = (idx == q_head.last_idx);
  assign xfer      = out_valid && !out_stall;
  assign q_pop     = xfer && at_last;

  always_comb begin
    out_item.out_byte    = q_head.res[idx].out_byte;
    out_item.kind        = q_head.res[idx].kind;
    out_item.last_in_run = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/shell_word_tokenizer.sv =====
// Top level of the shell word tokenizer.
`default_nettype none
// Splits a command line, one byte per input transfer, into words. Each byte
// yields zero to four results: word bytes (kind 0), a word-complete mark
// (kind 1) and, on the byte flagged line_last, a line-complete mark (kind 2);
// last_in_run flags the final result of a byte. Blanks split words outside
// quotes, single quotes make bytes literal, double quotes keep blanks and
// honor backslash only before a double quote or backslash; empty words are
// never reported. The front end takes one byte per cycle while the queue is
// not full and hands each byte's results as one bundle to a two-entry queue;
// the back end presents one result per cycle unless out_stall is high. Input
// runs at one byte per cycle while each yields at most one result and output
// is not stalled; a byte with several results holds the output until all are
// out. Input stalls only on a full queue; no-result bytes never enter it.
module shell_word_tokenizer
  import swt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  bundle_t q_in;
  bundle_t q_head;

  // Classify bytes and track quote / escape state.
  swt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Decouples the two sides so each can stall on its own.
  swt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Serialize each bundle into output transfers.
  swt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for the shell word tokenizer: directed and random lines against a predictor.
module tb;
  import swt_pkg::*;

  // Every input of the block starts out at a known value.
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  shell_word_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Splitter state, mirrored from the block's behavior.
  quote_t quote_st       = Q_NONE;
  esc_t   esc_st         = ESC_NONE;
  logic   word_has_bytes = 1'b0;

  // Tokens of the byte being predicted, tokens still owed by the block,
  // and command-line bytes waiting to be driven.
  out_item_t char_tokens[$];
  out_item_t pending_tokens[$];
  in_item_t  line_chars[$];

  // Phase knobs, written by the sequencer at the falling edge only.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_id       = 0;

  // Owned by the receiver process.
  int hold_seen = 0;
  int hold_left = 0;

  int mismatches = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // At most MAX_RES tokens per input byte; anything beyond is dropped.
  function automatic void emit(logic [7:0] b, kind_t k);
    out_item_t t;
    if (char_tokens.size() < MAX_RES) begin
      t.out_byte    = b;
      t.kind        = k;
      t.last_in_run = 1'b0;
      char_tokens   = {char_tokens, t};
    end
  endfunction

  function automatic void emit_byte(logic [7:0] b);
    emit(b, KIND_BYTE);
    word_has_bytes = 1'b1;
  endfunction

  // A byte with no escape in front of it.
  function automatic void plain_char(logic [7:0] c);
    if (c == CH_BSLASH) begin
      // Literal inside single quotes, arms an escape elsewhere.
      if (quote_st == Q_SINGLE) emit_byte(c);
      else if (quote_st == Q_DOUBLE) esc_st = ESC_DOUBLE;
      else esc_st = ESC_PLAIN;
    end else if (c == CH_SQUOTE) begin
      if (quote_st == Q_DOUBLE) emit_byte(c);
      else if (quote_st == Q_SINGLE) quote_st = Q_NONE;
      else quote_st = Q_SINGLE;
    end else if (c == CH_DQUOTE) begin
      if (quote_st == Q_SINGLE) emit_byte(c);
      else if (quote_st == Q_DOUBLE) quote_st = Q_NONE;
      else quote_st = Q_DOUBLE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      // Blanks are kept in quotes; outside they close a non-empty word.
      if (quote_st != Q_NONE) begin
        emit_byte(c);
      end else if (word_has_bytes) begin
        emit(8'h00, KIND_WORD);
        word_has_bytes = 1'b0;
      end
    end else begin
      emit_byte(c);
    end
  endfunction

  // Works out the tokens of one accepted byte and queues them.
  function automatic void split_char(in_item_t it);
    case (esc_st)
      ESC_PLAIN: begin
        esc_st = ESC_NONE;
        emit_byte(it.in_byte);
      end
      ESC_DOUBLE: begin
        // In double quotes only a quote or backslash is escaped; otherwise
        // the backslash stays and the byte is handled as usual.
        esc_st = ESC_NONE;
        if (it.in_byte == CH_DQUOTE || it.in_byte == CH_BSLASH) begin
          emit_byte(it.in_byte);
        end else begin
          emit_byte(CH_BSLASH);
          plain_char(it.in_byte);
        end
      end
      default: plain_char(it.in_byte);
    endcase
    if (it.line_last) begin
      // Trailing backslash: kept in double quotes, dropped outside.
      if (esc_st == ESC_DOUBLE) emit_byte(CH_BSLASH);
      esc_st = ESC_NONE;
      // An unterminated quote still completes its word.
      if (word_has_bytes) emit(8'h00, KIND_WORD);
      emit(8'h00, KIND_LINE);
      quote_st       = Q_NONE;
      word_has_bytes = 1'b0;
    end
    if (char_tokens.size() != 0) char_tokens[char_tokens.size() - 1].last_in_run = 1'b1;
    pending_tokens = {pending_tokens, char_tokens};
    char_tokens.delete();
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one byte per transfer, idling at random between offers.
  // A stalled byte is held unchanged; valid never looks at stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) split_char(in_item);
      if (!in_valid || !in_stall) begin
        if (line_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= line_chars.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every output transfer against the oldest owed token
  // and drives stall, including the long hold-off of the pressure phase.
  // ---------------------------------------------------------------------
  function automatic void report(string what, out_item_t exp, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
               $realtime, what, exp.out_byte, exp.kind, exp.last_in_run,
               got.out_byte, got.kind, got.last_in_run);
  endfunction

  always @(posedge clk) begin
    out_item_t exp;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          report("result with nothing owed", '0, out_item);
        end else begin
          exp = pending_tokens.pop_front();
          if (out_item.out_byte !== exp.out_byte || out_item.kind !== exp.kind ||
              out_item.last_in_run !== exp.last_in_run)
            report("token mismatch", exp, out_item);
        end
      end
      // A new hold request starts a long stall counted here.
      if (hold_id != hold_seen) begin
        hold_seen <= hold_id;
        hold_left <= 150;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic void push_char(logic [7:0] b, logic last);
    in_item_t it;
    it.in_byte   = b;
    it.line_last = last;
    line_chars   = {line_chars, it};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endfunction

  // One random command line; most are shell-like, some are raw noise.
  // Returns the number of bytes queued.
  function automatic int random_line();
    int          n;
    int          r;
    bit          noise;
    logic [7:0]  ch;
    n     = ($urandom_range(9) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 10);
    noise = ($urandom_range(4) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (noise || r >= 78) ch = 8'($urandom_range(255));
      else if (r < 36) ch = 8'h61 + 8'($urandom_range(25));
      else if (r < 50) ch = $urandom_range(1) ? CH_SPACE : CH_TAB;
      else if (r < 58) ch = CH_SQUOTE;
      else if (r < 66) ch = CH_DQUOTE;
      else ch = CH_BSLASH;
      push_char(ch, i == n - 1);
    end
    return n;
  endfunction

  // Block is idle once every byte is in and every owed token has come out.
  task automatic wait_drained();
    while (line_chars.size() != 0 || in_valid || pending_tokens.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(int send_pct, int stall, int n_chars, bit hold);
    int added;
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    added         = 0;
    while (added < n_chars) added += random_line();
    // Sender keeps offering during the hold so the result queue fills.
    if (hold) hold_id++;
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed lines, no idling.
    @(negedge clk);
    // Empty quote pairs, a blank split, trailing backslash dropped.
    push_text("''\"\"x y\\");
    // Escaped quote and backslash in double quotes, backslash kept before
    // another byte, trailing backslash kept in an unterminated quote.
    push_text("\"a\\\"\\\\\\q\\");
    // Single quotes: backslash and blank literal; unterminated at line end.
    push_text("'\\ \"");
    // Byte extremes, and an escape in double quotes giving four tokens.
    push_char(8'h00, 1'b0);
    push_char(CH_DQUOTE, 1'b0);
    push_char(CH_BSLASH, 1'b0);
    push_char(8'hff, 1'b1);
    // Lone blank ending a line: only the line mark.
    push_char(CH_TAB, 1'b1);
    wait_drained();

    // Random lines under the idling phases.
    run_phase(0, 0, 50, 1'b0);
    run_phase(80, 0, 45, 1'b0);
    run_phase(0, 80, 45, 1'b0);
    run_phase(38, 38, 45, 1'b0);
    run_phase(0, 20, 45, 1'b1);

    // Let any stray extra tokens show up before deciding.
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("shell_word_tokenizer test passed");
    end else begin
      $display("shell_word_tokenizer test failed");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #2000000;
    $display("shell_word_tokenizer test failed");
    $finish;
  end

endmodule
